// ----- rtl/bdmd_pkg.sv -----
package bdmd_pkg;

    localparam int DATA_W             = 8;
    localparam int COUNT_W            = 21;
    localparam int CFG_W              = 21;
    localparam int DEFAULT_MAX_PIXELS = 1048576;

    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd25;
    localparam logic [CFG_W-1:0]  FRAME_RESET     = 21'd307200;

    typedef enum logic [0:0] {
        CFG_THRESHOLD    = 1'b0,
        CFG_FRAME_PIXELS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] pixel;
        logic [DATA_W-1:0] bg;
        logic [DATA_W-1:0] thr;
        logic              compared;
    } t_upd_in;

    typedef struct packed {
        logic              motion;
        logic [DATA_W-1:0] new_bg;
    } t_upd_out;

endpackage

// ----- rtl/bdmd_pix_if.sv -----
interface bdmd_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bdmd_pkg::DATA_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/bdmd_res_if.sv -----
interface bdmd_res_if;
    logic                          valid;
    logic                          ready;
    logic                          motion;
    logic [bdmd_pkg::COUNT_W-1:0]  motion_count;
    logic                          frame_end;
    logic                          compared;

    modport source (output valid, output motion, output motion_count, output frame_end,
                    output compared, input ready);
    modport sink   (input valid, input motion, input motion_count, input frame_end,
                    input compared, output ready);
endinterface

// ----- rtl/bdmd_ram.sv -----
module bdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a same-address read returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bdmd_update.sv -----
module bdmd_update (
    input  bdmd_pkg::t_upd_in  i_upd,
    output bdmd_pkg::t_upd_out o_upd
);

    logic [bdmd_pkg::DATA_W:0]      diff;
    logic [bdmd_pkg::DATA_W+4:0]    blend;

    always_comb begin
        if (i_upd.pixel > i_upd.bg) begin
            diff = {1'b0, i_upd.pixel} - {1'b0, i_upd.bg};
        end else begin
            diff = {1'b0, i_upd.bg} - {1'b0, i_upd.pixel};
        end
        // bg*31 + p = bg*32 - bg + p, never negative
        blend = {i_upd.bg, 5'b0} - {5'b0, i_upd.bg} + {5'b0, i_upd.pixel};

        o_upd.motion = i_upd.compared && (diff > {1'b0, i_upd.thr});
        o_upd.new_bg = i_upd.compared ? blend[bdmd_pkg::DATA_W+4:5] : i_upd.pixel;
    end

endmodule

// ----- rtl/background_diff_motion_detector_core.sv -----
// Background-difference motion detector.
// i_pix carries one 8-bit luma pixel per request in raster order; o_res returns one
// result per pixel: motion flag, running motion count for the frame, frame_end on
// the last pixel, and compared (0 during background capture).
// The config port writes the threshold (index 0) or the frame size (index 1); a frame
// size write restarts at pixel 0 and recaptures the background.
// The background word is read from the frame store at accept, compared and blended in
// the compare stage, and loaded into the result register as the blended word is
// written back.
// Throughput is one pixel per cycle unless o_res stalls, set by the separate read and
// write ports of the background store; a one-pixel frame forwards the written word.
// When o_res stalls, one more pixel is taken into the compare stage, then i_pix
// ready drops until the result is taken.
// Reset clears the pipeline, pixel position, tally and background-valid flag and
// loads threshold 25 and frame size 307200; the first frame after it is a capture.
module background_diff_motion_detector_core #(
    parameter int MAX_PIXELS = bdmd_pkg::DEFAULT_MAX_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bdmd_pix_if.sink                      i_pix,
    bdmd_res_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  bdmd_pkg::t_cfg_idx            i_cfg_index,
    input  logic [bdmd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int NW = (AW + 1 > 22) ? AW + 1 : 22;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_PIXELS);

    logic [bdmd_pkg::DATA_W-1:0]  r_thr;
    logic [bdmd_pkg::CFG_W-1:0]   r_frame_pixels;
    logic                         r_bg_valid;
    logic [AW-1:0]                r_pos;
    logic [bdmd_pkg::COUNT_W-1:0] r_tally;

    logic                         r_s1_valid;
    logic [bdmd_pkg::DATA_W-1:0]  r_s1_pixel;
    logic [AW-1:0]                r_s1_addr;
    logic                         r_s1_last;
    logic                         r_s1_cmp;
    logic                         r_fwd;
    logic [bdmd_pkg::DATA_W-1:0]  r_fwd_data;

    logic                         r_s2_valid;
    logic                         r_s2_motion;
    logic [bdmd_pkg::COUNT_W-1:0] r_s2_count;
    logic                         r_s2_last;
    logic                         r_s2_cmp;

    logic [NW-1:0]                fp_ext;
    logic [NW-1:0]                n_eff;
    logic [NW-1:0]                pos_eff;
    logic                         last;
    logic                         accept;
    logic                         s1_adv;
    logic [bdmd_pkg::DATA_W-1:0]  rd_data;
    logic [bdmd_pkg::COUNT_W-1:0] n_tally;
    bdmd_pkg::t_upd_in            upd_in;
    bdmd_pkg::t_upd_out           upd_out;

    always_comb begin
        fp_ext = {{(NW-bdmd_pkg::CFG_W){1'b0}}, r_frame_pixels};
        if (fp_ext == '0) begin
            n_eff = NW'(1);
        end else if (fp_ext > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = fp_ext;
        end
        pos_eff = {{(NW-AW){1'b0}}, r_pos};
        if (pos_eff >= n_eff) begin
            pos_eff = '0;
        end
        last = ((pos_eff + NW'(1)) == n_eff);
    end

    assign s1_adv      = r_s1_valid && (!r_s2_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    bdmd_ram #(
        .WIDTH (bdmd_pkg::DATA_W),
        .DEPTH (MAX_PIXELS)
    ) u_bg_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (upd_out.new_bg),
        .i_re    (accept),
        .i_raddr (pos_eff[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        upd_in.pixel    = r_s1_pixel;
        upd_in.bg       = r_fwd ? r_fwd_data : rd_data;
        upd_in.thr      = r_thr;
        upd_in.compared = r_s1_cmp;
    end

    bdmd_update u_update (
        .i_upd (upd_in),
        .o_upd (upd_out)
    );

    assign n_tally = r_tally + bdmd_pkg::COUNT_W'(upd_out.motion);

    // config, frame position and capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr          <= bdmd_pkg::THRESHOLD_RESET;
            r_frame_pixels <= bdmd_pkg::FRAME_RESET;
            r_bg_valid     <= 1'b0;
            r_pos          <= '0;
            r_tally        <= '0;
        end else if (i_cfg_we && (i_cfg_index == bdmd_pkg::CFG_FRAME_PIXELS)) begin
            r_frame_pixels <= i_cfg_data;
            r_bg_valid     <= 1'b0;
            r_pos          <= '0;
            r_tally        <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == bdmd_pkg::CFG_THRESHOLD)) begin
                r_thr <= i_cfg_data[bdmd_pkg::DATA_W-1:0];
            end
            if (accept) begin
                r_pos <= last ? '0 : AW'(pos_eff + NW'(1));
                if (last) begin
                    r_bg_valid <= 1'b1;
                end
            end
            if (s1_adv) begin
                r_tally <= r_s1_last ? '0 : n_tally;
            end
        end
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pix.pixel;
            r_s1_addr  <= pos_eff[AW-1:0];
            r_s1_last  <= last;
            r_s1_cmp   <= r_bg_valid;
            // one-pixel frame: the word being written back is the one just read
            r_fwd      <= s1_adv && (r_s1_addr == pos_eff[AW-1:0]);
            r_fwd_data <= upd_out.new_bg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_motion <= upd_out.motion;
            r_s2_count  <= r_s1_cmp ? n_tally : '0;
            r_s2_last   <= r_s1_last;
            r_s2_cmp    <= r_s1_cmp;
        end
    end

    assign o_res.valid        = r_s2_valid;
    assign o_res.motion       = r_s2_motion;
    assign o_res.motion_count = r_s2_count;
    assign o_res.frame_end    = r_s2_last;
    assign o_res.compared     = r_s2_cmp;

    a_capture_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.compared) |-> (!o_res.motion && (o_res.motion_count == '0)))
        else $error("capture result reports motion");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1_valid && r_s2_valid))
        else $error("input stalled with free stage");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && !o_res.ready) |=> r_s1_valid)
        else $error("compare stage lost a pixel");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == bdmd_pkg::CFG_FRAME_PIXELS))
        |=> (!r_bg_valid && (r_pos == '0) && (r_tally == '0)))
        else $error("frame size write did not rearm capture");

endmodule
